/* hdl/k_way_sorted_list_merge_macros.svh */
// Assertion macros for the k-way merge block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef K_WAY_SORTED_LIST_MERGE_MACROS_SVH
`define K_WAY_SORTED_LIST_MERGE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/kwm_pkg.sv */
// Shared types and constants for the k-way merge block.
// No dependencies.
package kwm_pkg;

   localparam int VALUE_W      = 32;
   localparam int LIST_FIELD_W = 2;

   typedef struct packed {
      logic [LIST_FIELD_W-1:0]   list_index;
      logic signed [VALUE_W-1:0] element_value;
      logic                      last_item;
   } kwm_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] merged_value;
      logic [LIST_FIELD_W-1:0]   source_list;
      logic                      last_out;
      logic                      overflow;
   } kwm_rsp_type;

   typedef enum logic [1:0] {
      KWM_IDLE,
      KWM_SCAN,
      KWM_WAIT,
      KWM_EMIT
   } kwm_state_type;

   // Controls for the head comparator.
   typedef struct packed {
      logic clear;
      logic cand;
   } kwm_pick_ctl_type;

endpackage

/* hdl/kwm_ram.sv */
// List store: single write port, single registered read port.
// Depends on kwm_pkg for the value width.
module kwm_ram import kwm_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic signed [VALUE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic signed [VALUE_W-1:0] rd_data
);

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kwm_pick.sv */
// Running minimum over the list heads read during one scan.
// Depends on kwm_pkg for the control struct and value width.
module kwm_pick import kwm_pkg::*; #(
   parameter int LW = 2,
   parameter int DW = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kwm_pick_ctl_type          ctl,
   input  logic [LW-1:0]             cand_list,
   input  logic [DW-1:0]             cand_slot,
   input  logic signed [VALUE_W-1:0] cand_value,
   output logic                      best_found,
   output logic [LW-1:0]             best_list,
   output logic [DW-1:0]             best_slot,
   output logic signed [VALUE_W-1:0] best_value
);

   logic                      found_ff, found_in;
   logic [LW-1:0]             list_ff, list_in;
   logic [DW-1:0]             slot_ff, slot_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      take;

   // Lists are scanned in ascending order, so strict less keeps the lower index on a tie
   assign take = ctl.cand && (!found_ff || (cand_value < value_ff));

   always_comb begin
      found_in = found_ff;
      list_in  = list_ff;
      slot_in  = slot_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         list_in  = cand_list;
         slot_in  = cand_slot;
         value_in = cand_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff  <= list_in;
      slot_ff  <= slot_in;
      value_ff <= value_in;
   end

   assign best_found = found_ff;
   assign best_list  = list_ff;
   assign best_slot  = slot_ff;
   assign best_value = value_ff;

endmodule

/* hdl/k_way_sorted_list_merge.sv */
// Loading: items are taken back to back while idle; busy stays low between items.
// Merge: an item with last_item starts it; for each result the single read port of the
// list store fetches one list head per cycle for comparison.
// The first result strobes from the output register loaded in EMIT, after SCAN and WAIT.
// Synchronous reset clears counts, read heads, overflow flag and control; the list store
// is not cleared (entries are read only below the fill count). Results cannot be stalled.
`include "k_way_sorted_list_merge_macros.svh"

module k_way_sorted_list_merge import kwm_pkg::*; #(
   parameter int NUM_LISTS  = 4,
   parameter int LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  kwm_req_type req_item,
   output logic        busy,
   output logic        rsp_valid,
   output kwm_rsp_type rsp_item
);

   localparam int LW        = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int DW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW        = $clog2(LIST_DEPTH + 1);
   localparam int TW        = $clog2(NUM_LISTS * LIST_DEPTH + 1);
   localparam int AW        = LW + DW;
   localparam int MEM_DEPTH = NUM_LISTS * (2 ** DW);

   kwm_state_type state_ff, state_in;
   logic [LW-1:0] scan_ff, scan_in;
   logic [CW-1:0] fill_ff [NUM_LISTS];
   logic [CW-1:0] fill_in [NUM_LISTS];
   logic [CW-1:0] head_ff [NUM_LISTS];
   logic [CW-1:0] head_in [NUM_LISTS];
   logic [TW-1:0] total_ff, total_in;
   logic          ovf_ff, ovf_in;
   logic          cand_vld_ff, cand_vld_in;
   logic [LW-1:0] cand_list_ff, cand_list_in;
   logic [DW-1:0] cand_slot_ff, cand_slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   kwm_rsp_type   rsp_ff, rsp_in;

   logic          accept;
   logic          in_range;
   logic [LW-1:0] req_list;
   logic [LW-1:0] ptr;
   logic [CW-1:0] ptr_fill;
   logic [CW-1:0] ptr_head;
   logic          has_room;
   logic          do_write;
   logic [TW-1:0] total_inc;
   logic          scan_last;
   logic          rd_en;
   logic          merge_go;

   logic signed [VALUE_W-1:0] rd_data;
   kwm_pick_ctl_type          pick_ctl;
   logic                      best_found;
   logic [LW-1:0]             best_list;
   logic [DW-1:0]             best_slot;
   logic signed [VALUE_W-1:0] best_value;

   assign accept    = start && (state_ff == KWM_IDLE);
   assign in_range  = (32'(req_item.list_index) < 32'(NUM_LISTS));
   assign req_list  = LW'(req_item.list_index);
   // one shared index into the count arrays: load list when idle, scan list otherwise
   assign ptr       = (state_ff == KWM_IDLE) ? req_list : scan_ff;
   assign ptr_fill  = fill_ff[ptr];
   assign ptr_head  = head_ff[ptr];
   assign has_room  = (ptr_fill < CW'(LIST_DEPTH));
   assign do_write  = accept && in_range && has_room;
   assign total_inc = total_ff + TW'(do_write);
   assign scan_last = (scan_ff == LW'(NUM_LISTS - 1));
   assign rd_en     = (state_ff == KWM_SCAN) && (ptr_head < ptr_fill);
   assign merge_go  = accept && req_item.last_item;

   kwm_ram #(
      .DEPTH (MEM_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr ({req_list, ptr_fill[DW-1:0]}),
      .wr_data (req_item.element_value),
      .rd_en   (rd_en),
      .rd_addr ({scan_ff, ptr_head[DW-1:0]}),
      .rd_data (rd_data)
   );

   assign pick_ctl.clear = merge_go || (state_ff == KWM_EMIT);
   assign pick_ctl.cand  = cand_vld_ff;

   kwm_pick #(
      .LW (LW),
      .DW (DW)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .cand_list  (cand_list_ff),
      .cand_slot  (cand_slot_ff),
      .cand_value (rd_data),
      .best_found (best_found),
      .best_list  (best_list),
      .best_slot  (best_slot),
      .best_value (best_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         KWM_IDLE: begin
            if (merge_go && (total_inc != '0)) begin
               state_in = KWM_SCAN;
            end
         end
         KWM_SCAN: begin
            if (scan_last) begin
               state_in = KWM_WAIT;
            end
         end
         KWM_WAIT: begin
            state_in = KWM_EMIT;
         end
         KWM_EMIT: begin
            state_in = (total_ff == TW'(1)) ? KWM_IDLE : KWM_SCAN;
         end
         default: begin
            state_in = KWM_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      scan_in      = scan_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      cand_vld_in  = 1'b0;
      cand_list_in = cand_list_ff;
      cand_slot_in = cand_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         KWM_IDLE: begin
            scan_in = '0;
            if (do_write) begin
               fill_in[req_list] = ptr_fill + CW'(1);
               total_in          = total_inc;
            end
            if (accept && in_range && !has_room) begin
               ovf_in = 1'b1;
            end
         end
         KWM_SCAN: begin
            cand_vld_in  = rd_en;
            cand_list_in = scan_ff;
            cand_slot_in = ptr_head[DW-1:0];
            scan_in      = scan_last ? '0 : scan_ff + LW'(1);
         end
         KWM_WAIT: begin
         end
         KWM_EMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.merged_value  = best_value;
            rsp_in.source_list   = LIST_FIELD_W'(best_list);
            rsp_in.last_out      = (total_ff == TW'(1));
            rsp_in.overflow      = ovf_ff;
            head_in[best_list]   = CW'(best_slot) + CW'(1);
            total_in             = total_ff - TW'(1);
            if (total_ff == TW'(1)) begin
               for (int i = 0; i < NUM_LISTS; i++) begin
                  fill_in[i] = '0;
                  head_in[i] = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= KWM_IDLE;
         scan_ff      <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         cand_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         cand_vld_ff  <= cand_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_list_ff <= cand_list_in;
      cand_slot_ff <= cand_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != KWM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `KWM_ASSERT_NOW(a_rsp_after_emit, clock, reset, rsp_valid, $past(state_ff == KWM_EMIT),
      "result strobe without a preceding emit cycle")
   `KWM_ASSERT_NOW(a_emit_has_best, clock, reset, state_ff == KWM_EMIT, best_found,
      "emit cycle with no list head selected")
   `KWM_ASSERT_NOW(a_scan_has_work, clock, reset, state_ff != KWM_IDLE, total_ff != '0,
      "merge running with nothing left to emit")
   `KWM_ASSERT_NOW(a_last_ends_run, clock, reset, rsp_valid && rsp_item.last_out,
      (state_ff == KWM_IDLE) && (total_ff == '0), "final result while merge still running")
   `KWM_ASSERT_NEXT(a_cand_follows_read, clock, reset, rd_en, cand_vld_ff,
      "list head read not passed to the comparator")

endmodule

/* tb/k_way_sorted_list_merge_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for k_way_sorted_list_merge: streams tagged sorted lists,
// keeps its own merge of each data set and compares every merged result in order.
// Depends on kwm_pkg and the k_way_sorted_list_merge RTL only.
module k_way_sorted_list_merge_tb;
   import kwm_pkg::*;

   localparam int LISTS = 4;
   localparam int DEPTH = 16;
   localparam int TARGET_ELEMENTS = 525;
   localparam longint MIN_VAL = -64'sd2147483648;
   localparam longint MAX_VAL = 64'sd2147483647;

   typedef struct {
      kwm_req_type item;
      bit          drain_first;   // hold off until every merged result is back
   } feed_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   kwm_req_type req_item = '0;
   logic        busy;
   logic        rsp_valid;
   kwm_rsp_type rsp_item;

   feed_entry_type feed_q[$];
   kwm_rsp_type    merged_due[$];

   // Own copy of the list memory, fill levels and sticky overflow flag
   logic signed [VALUE_W-1:0] list_mem [LISTS][DEPTH];
   int  fill_level [LISTS];
   bit  overflow_flag;

   int idle_left;
   int burst_left;
   int mismatches;
   int elements_sent;
   int merges_started;
   int merged_seen;
   int merged_after_overflow;

   k_way_sorted_list_merge #(
      .NUM_LISTS  (LISTS),
      .LIST_DEPTH (DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d merged results outstanding", merged_due.size());
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 50)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Appends one element; on last_item merges every list into merged_due.
   task automatic load_and_merge(input kwm_req_type it);
      int head [LISTS];
      int total;
      int best;
      int lst;
      kwm_rsp_type r;
      lst = int'(it.list_index);
      if (lst < LISTS) begin
         if (fill_level[lst] < DEPTH) begin
            list_mem[lst][fill_level[lst]] = it.element_value;
            fill_level[lst]++;
         end else begin
            overflow_flag = 1'b1;
         end
      end
      if (it.last_item) begin
         merges_started++;
         total = 0;
         for (int i = 0; i < LISTS; i++) begin
            head[i] = 0;
            total += fill_level[i];
         end
         for (int n = 0; n < total; n++) begin
            best = -1;
            // strict less-than keeps the lowest list on equal heads
            for (int i = 0; i < LISTS; i++)
               if (head[i] < fill_level[i] &&
                   (best < 0 || list_mem[i][head[i]] < list_mem[best][head[best]]))
                  best = i;
            r.merged_value = list_mem[best][head[best]];
            r.source_list  = LIST_FIELD_W'(best);
            r.last_out     = (n == total - 1);
            r.overflow     = overflow_flag;
            merged_due = {merged_due, r};
            head[best]++;
         end
         for (int i = 0; i < LISTS; i++)
            fill_level[i] = 0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (r < 3) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_element(input int lst, input longint val, input bit last,
                               input bit drain);
      feed_entry_type e;
      e.item.list_index    = LIST_FIELD_W'(lst);
      e.item.element_value = VALUE_W'(val);
      e.item.last_item     = last;
      e.drain_first        = drain;
      feed_q = {feed_q, e};
   endtask

   // One data set: per-list ascending runs (occasionally unsorted), interleaved at random.
   task automatic build_random_set();
      longint vals [LISTS][DEPTH+2];
      int     cnt [LISTS];
      int     taken [LISTS];
      int     remaining;
      int     shape;
      int     mode;
      int     lst;
      longint cur;
      bit     drain;
      bit     unsorted;
      shape     = $urandom_range(0, 99);
      mode      = $urandom_range(0, 3);
      unsorted  = ($urandom_range(0, 9) == 0);
      remaining = 0;
      cur       = 0;
      for (int i = 0; i < LISTS; i++) begin
         if (shape < 82)
            cnt[i] = $urandom_range(0, 3);
         else if (shape < 96)
            cnt[i] = $urandom_range(0, 10);
         else
            cnt[i] = ($urandom_range(0, 2) == 0) ? DEPTH + $urandom_range(1, 2) : DEPTH;
         taken[i] = 0;
         case (mode)
            0:       cur = longint'($signed($urandom()));
            1:       cur = longint'($urandom_range(0, 16)) - 64'sd8;
            2:       cur = MIN_VAL + longint'($urandom_range(0, 4));
            default: cur = MAX_VAL - longint'($urandom_range(0, 40));
         endcase
         for (int j = 0; j < cnt[i]; j++) begin
            if (unsorted) begin
               vals[i][j] = longint'($signed($urandom()));
            end else begin
               vals[i][j] = cur;
               if (mode == 0)
                  cur += longint'($urandom_range(0, 32'h0400_0000));
               else
                  cur += longint'($urandom_range(0, 3));
               if (cur > MAX_VAL)
                  cur = MAX_VAL;
            end
         end
         remaining += cnt[i];
      end
      if (remaining == 0) begin
         lst = $urandom_range(0, LISTS - 1);
         cnt[lst] = 1;
         vals[lst][0] = cur;
         remaining = 1;
      end
      drain = ($urandom_range(0, 6) == 0);
      while (remaining > 0) begin
         lst = $urandom_range(0, LISTS - 1);
         while (taken[lst] == cnt[lst])
            lst = (lst + 1) % LISTS;
         push_element(lst, vals[lst][taken[lst]], remaining == 1, drain);
         drain = 1'b0;
         taken[lst]++;
         remaining--;
      end
   endtask

   // Driver: one element per transfer, random idle cycles in between
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         req_item  <= '0;
         idle_left  = 0;
      end else if (!(start && busy)) begin
         if (start) begin
            load_and_merge(req_item);
            elements_sent++;
            idle_left = pick_gap();
         end
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (feed_q.size() == 0 ||
                      (feed_q[0].drain_first && merged_due.size() != 0)) begin
            start <= 1'b0;
         end else begin
            req_item <= feed_q[0].item;
            start    <= 1'b1;
            void'(feed_q.pop_front());
         end
      end
   end

   // Monitor: results cannot be stalled, so every strobe is a transfer
   always @(posedge clock) begin
      kwm_rsp_type want;
      if (!reset && rsp_valid) begin
         merged_seen++;
         if (rsp_item.overflow)
            merged_after_overflow++;
         if (merged_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d from list %0d",
                                      rsp_item.merged_value, rsp_item.source_list));
         end else begin
            want = merged_due.pop_front();
            if (rsp_item.merged_value !== want.merged_value)
               report_mismatch($sformatf("merged_value %0d, expected %0d",
                                         rsp_item.merged_value, want.merged_value));
            if (rsp_item.source_list !== want.source_list)
               report_mismatch($sformatf("source_list %0d, expected %0d",
                                         rsp_item.source_list, want.source_list));
            if (rsp_item.last_out !== want.last_out)
               report_mismatch($sformatf("last_out %0b, expected %0b",
                                         rsp_item.last_out, want.last_out));
            if (rsp_item.overflow !== want.overflow)
               report_mismatch($sformatf("overflow %0b, expected %0b",
                                         rsp_item.overflow, want.overflow));
         end
      end
   end

   initial begin : run_control
      for (int i = 0; i < LISTS; i++)
         fill_level[i] = 0;
      overflow_flag = 1'b0;

      // extremes spread over all lists, equal heads in lists 0/1
      push_element(0, MIN_VAL, 1'b0, 1'b0);
      push_element(1, MIN_VAL, 1'b0, 1'b0);
      push_element(2, -1, 1'b0, 1'b0);
      push_element(3, 0, 1'b0, 1'b0);
      push_element(0, 5, 1'b0, 1'b0);
      push_element(1, 5, 1'b0, 1'b0);
      push_element(3, MAX_VAL, 1'b1, 1'b0);
      // single-element data set
      push_element(2, 77, 1'b1, 1'b1);
      // list 2 full; the dropped final element must still start the merge
      for (int j = 0; j < DEPTH; j++)
         push_element(2, j * 3, 1'b0, j == 0);
      push_element(2, -5, 1'b1, 1'b0);

      while (feed_q.size() < TARGET_ELEMENTS)
         build_random_set();

      do @(posedge clock); while (reset);
      do @(posedge clock);
      while (feed_q.size() != 0 || start || merged_due.size() != 0);
      repeat (LISTS + 20) @(posedge clock);

      $display("Ran %0d element transfers into %0d merges; %0d merged results checked,",
               elements_sent, merges_started, merged_seen);
      $display("%0d of them with the overflow flag up; %0d mismatches.",
               merged_after_overflow, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/kwm_pkg.sv
hdl/kwm_ram.sv
hdl/kwm_pick.sv
hdl/k_way_sorted_list_merge.sv
tb/k_way_sorted_list_merge_tb.sv
